@@ sv/xbar_chart_run_length_monitor_assert.svh @@
`ifndef XBAR_CHART_RUN_LENGTH_MONITOR_ASSERT_SVH
`define XBAR_CHART_RUN_LENGTH_MONITOR_ASSERT_SVH

// Same-cycle implication, sampled at every rising edge outside reset
`define XRLM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled at every rising edge outside reset
`define XRLM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/xrlm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package xrlm_pkg;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int LIMIT_W    = 16;
    localparam int SIZE_W     = 5;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int COUNT_W    = 16;
    localparam int LSUM_W     = 32;
    localparam int SQSUM_W    = 48;

    // Register reset values
    localparam logic signed [LIMIT_W-1:0] LOWER_RESET = -16'sd5495;
    localparam logic signed [LIMIT_W-1:0] UPPER_RESET = 16'sd5495;
    localparam logic [SIZE_W-1:0]         SIZE_RESET  = 5'd5;

    // Saturation ceilings
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [LSUM_W-1:0]  LSUM_MAX  = 32'hFFFF_FFFF;
    localparam logic [SQSUM_W-1:0] SQSUM_MAX = 48'hFFFF_FFFF_FFFF;

    // Prior in-control count thresholds for the short-run counters
    localparam logic [7:0] THRESH_50  = 8'd50;
    localparam logic [7:0] THRESH_100 = 8'd100;
    localparam logic [7:0] THRESH_200 = 8'd200;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_LOWER = 2'd0,
        CFG_UPPER = 2'd1,
        CFG_SIZE  = 2'd2
    } cfg_index_t;

    typedef enum logic {
        OP_SAMPLE   = 1'b0,
        OP_END_USER = 1'b1
    } op_t;

    // Classified word from front to back
    typedef struct packed {
        logic end_user;
        logic done;
        logic bad;
    } mid_word_t;

    // Result word as shown on the result ports
    typedef struct packed {
        logic               subgroup_done;
        logic               alarm;
        logic [COUNT_W-1:0] run_length;
        logic [COUNT_W-1:0] alarm_total;
        logic [LSUM_W-1:0]  run_length_sum;
        logic [SQSUM_W-1:0] run_length_square_sum;
        logic [COUNT_W-1:0] runs_under_50;
        logic [COUNT_W-1:0] runs_under_100;
        logic [COUNT_W-1:0] runs_under_200;
    } res_word_t;

endpackage

`default_nettype wire

@@ sv/xrlm_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module xrlm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = store_reg[rd_ptr_reg];

    // Advance pointers with wrap, track occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ sv/xrlm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module xrlm_front #(
    parameter int MAX_SUBGROUP = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [xrlm_pkg::CFG_ADDR_W-1:0]        cfg_index,
    input  logic [xrlm_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                   accept,
    input  logic                                   op,
    input  logic signed [xrlm_pkg::SAMPLE_W-1:0]   sample,
    output xrlm_pkg::mid_word_t                    word
);

    import xrlm_pkg::*;

    localparam int SUM_W  = SAMPLE_W + $clog2(MAX_SUBGROUP);
    localparam int PROD_W = SUM_W + 1;
    localparam int N_W    = $clog2(MAX_SUBGROUP + 1);
    localparam int CMP_W  = (N_W > SIZE_W) ? N_W : SIZE_W;
    localparam logic [CMP_W-1:0] N_MAX = CMP_W'(MAX_SUBGROUP);

    logic signed [LIMIT_W-1:0] lower_limit_reg;
    logic signed [LIMIT_W-1:0] upper_limit_reg;
    logic [SIZE_W-1:0]         size_reg;

    logic signed [SUM_W-1:0]   partial_sum_reg, partial_sum_next;
    logic [N_W-1:0]            count_reg, count_next;

    logic [CMP_W-1:0]          size_wide;
    logic [CMP_W-1:0]          n_clamped;
    logic [N_W-1:0]            n_eff;
    logic signed [N_W:0]       n_signed;
    logic signed [PROD_W-1:0]  lo_prod;
    logic signed [PROD_W-1:0]  hi_prod;
    logic signed [SUM_W-1:0]   sum_new;
    logic signed [PROD_W-1:0]  sum_ext;
    logic [N_W-1:0]            count_new;
    logic                      done;
    logic                      bad;
    logic                      end_user;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_limit_reg <= LOWER_RESET;
            upper_limit_reg <= UPPER_RESET;
            size_reg        <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LOWER: lower_limit_reg <= $signed(cfg_data[LIMIT_W-1:0]);
                CFG_UPPER: upper_limit_reg <= $signed(cfg_data[LIMIT_W-1:0]);
                CFG_SIZE:  size_reg        <= cfg_data[SIZE_W-1:0];
                default:   ;
            endcase
        end
    end

    // Clamp the subgroup size into one to MAX_SUBGROUP
    always_comb
    begin
        size_wide = CMP_W'(size_reg);
        if (size_reg == '0)
        begin
            n_clamped = CMP_W'(1);
        end
        else if (size_wide > N_MAX)
        begin
            n_clamped = N_MAX;
        end
        else
        begin
            n_clamped = size_wide;
        end
    end

    assign n_eff    = N_W'(n_clamped);
    assign n_signed = $signed({1'b0, n_eff});

    // Scale the limits by the size so the mean test needs no divide
    assign lo_prod = PROD_W'(n_signed) * PROD_W'(lower_limit_reg);
    assign hi_prod = PROD_W'(n_signed) * PROD_W'(upper_limit_reg);

    // Accumulate and classify the word
    assign end_user  = (op_t'(op) == OP_END_USER);
    assign sum_new   = partial_sum_reg + SUM_W'(sample);
    assign sum_ext   = PROD_W'(sum_new);
    assign count_new = count_reg + N_W'(1);
    assign done      = (count_new >= n_eff);
    assign bad       = done && ((sum_ext < lo_prod) || (sum_ext > hi_prod));

    assign word.end_user = end_user;
    assign word.done     = !end_user && done;
    assign word.bad      = !end_user && bad;

    always_comb
    begin
        partial_sum_next = partial_sum_reg;
        count_next       = count_reg;
        if (accept)
        begin
            if (end_user || done)
            begin
                partial_sum_next = '0;
                count_next       = '0;
            end
            else
            begin
                partial_sum_next = sum_new;
                count_next       = count_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_sum_reg <= '0;
            count_reg       <= '0;
        end
        else
        begin
            partial_sum_reg <= partial_sum_next;
            count_reg       <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/xrlm_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module xrlm_back #(
    parameter int RUN_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                word_valid,
    input  xrlm_pkg::mid_word_t word,
    output logic                word_pop,
    input  logic                res_full,
    output logic                res_push,
    output xrlm_pkg::res_word_t res
);

    import xrlm_pkg::*;

    localparam int SQ_W   = 2 * RUN_BITS;
    localparam int RLC_W  = (RUN_BITS > COUNT_W) ? RUN_BITS : COUNT_W;
    localparam int ACC_W  = ((SQ_W > SQSUM_W) ? SQ_W : SQSUM_W) + 1;
    localparam logic [RUN_BITS-1:0] IC_MAX = {{(RUN_BITS-1){1'b1}}, 1'b0};

    // Running state
    logic [RUN_BITS-1:0] ic_reg, ic_next;
    logic [COUNT_W-1:0]  alarm_cnt_reg, alarm_cnt_next;
    logic [LSUM_W-1:0]   len_sum_reg, len_sum_next;
    logic [COUNT_W-1:0]  u50_reg, u50_next;
    logic [COUNT_W-1:0]  u100_reg, u100_next;
    logic [COUNT_W-1:0]  u200_reg, u200_next;
    logic [SQSUM_W-1:0]  sq_acc_reg, sq_acc_next;

    // Pipeline stages
    logic                s1_valid_reg;
    logic                s1_end_user_reg;
    logic [RUN_BITS-1:0] s1_rl_reg;
    res_word_t           s1_res_reg, s1_res_next;
    logic                s2_valid_reg;
    logic                s2_end_user_reg;
    logic [SQ_W-1:0]     s2_sq_reg;
    res_word_t           s2_res_reg;

    logic                adv;
    logic [RUN_BITS-1:0] rl;
    logic [RLC_W-1:0]    rl_wide;
    logic [COUNT_W-1:0]  rl_field;
    logic [LSUM_W:0]     len_sum_wide;
    logic [ACC_W-1:0]    sq_sum_wide;
    logic [SQSUM_W-1:0]  sq_sat;

    assign adv      = !res_full;
    assign word_pop = adv && word_valid;
    assign res_push = adv && s2_valid_reg;

    // Stage one: run length, counters and in-control count
    assign rl           = ic_reg + RUN_BITS'(1);
    assign rl_wide      = RLC_W'(rl);
    assign rl_field     = (rl_wide > RLC_W'(COUNT_MAX)) ? COUNT_MAX : rl_wide[COUNT_W-1:0];
    assign len_sum_wide = {1'b0, len_sum_reg} + (LSUM_W + 1)'(rl);

    always_comb
    begin
        ic_next        = ic_reg;
        alarm_cnt_next = alarm_cnt_reg;
        len_sum_next   = len_sum_reg;
        u50_next       = u50_reg;
        u100_next      = u100_reg;
        u200_next      = u200_reg;
        s1_res_next    = '0;
        if (word.end_user)
        begin
            // Report the totals held, then clear them
            s1_res_next.alarm_total    = alarm_cnt_reg;
            s1_res_next.run_length_sum = len_sum_reg;
            s1_res_next.runs_under_50  = u50_reg;
            s1_res_next.runs_under_100 = u100_reg;
            s1_res_next.runs_under_200 = u200_reg;
            ic_next        = '0;
            alarm_cnt_next = '0;
            len_sum_next   = '0;
            u50_next       = '0;
            u100_next      = '0;
            u200_next      = '0;
        end
        else
        begin
            if (word.bad)
            begin
                ic_next        = '0;
                alarm_cnt_next = (alarm_cnt_reg == COUNT_MAX) ? COUNT_MAX
                                                              : alarm_cnt_reg + COUNT_W'(1);
                len_sum_next   = len_sum_wide[LSUM_W] ? LSUM_MAX : len_sum_wide[LSUM_W-1:0];
                if (ic_reg < RUN_BITS'(THRESH_50) && u50_reg != COUNT_MAX)
                begin
                    u50_next = u50_reg + COUNT_W'(1);
                end
                if (ic_reg < RUN_BITS'(THRESH_100) && u100_reg != COUNT_MAX)
                begin
                    u100_next = u100_reg + COUNT_W'(1);
                end
                if (ic_reg < RUN_BITS'(THRESH_200) && u200_reg != COUNT_MAX)
                begin
                    u200_next = u200_reg + COUNT_W'(1);
                end
            end
            else if (word.done && ic_reg < IC_MAX)
            begin
                ic_next = ic_reg + RUN_BITS'(1);
            end
            s1_res_next.subgroup_done  = word.done;
            s1_res_next.alarm          = word.bad;
            s1_res_next.run_length     = word.bad ? rl_field : '0;
            s1_res_next.alarm_total    = alarm_cnt_next;
            s1_res_next.run_length_sum = len_sum_next;
            s1_res_next.runs_under_50  = u50_next;
            s1_res_next.runs_under_100 = u100_next;
            s1_res_next.runs_under_200 = u200_next;
        end
    end

    // Stage three: fold the square into its saturating sum
    assign sq_sum_wide = ACC_W'(sq_acc_reg) + ACC_W'(s2_sq_reg);
    assign sq_sat      = (sq_sum_wide > ACC_W'(SQSUM_MAX)) ? SQSUM_MAX
                                                           : sq_sum_wide[SQSUM_W-1:0];

    always_comb
    begin
        sq_acc_next = sq_acc_reg;
        res         = s2_res_reg;
        res.run_length_square_sum = sq_acc_reg;
        if (s2_end_user_reg)
        begin
            sq_acc_next = '0;
        end
        else if (s2_res_reg.alarm)
        begin
            sq_acc_next               = sq_sat;
            res.run_length_square_sum = sq_sat;
        end
    end

    // Hold running state; update on each word taken or delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ic_reg        <= '0;
            alarm_cnt_reg <= '0;
            len_sum_reg   <= '0;
            u50_reg       <= '0;
            u100_reg      <= '0;
            u200_reg      <= '0;
            sq_acc_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
        end
        else
        begin
            if (word_pop)
            begin
                ic_reg        <= ic_next;
                alarm_cnt_reg <= alarm_cnt_next;
                len_sum_reg   <= len_sum_next;
                u50_reg       <= u50_next;
                u100_reg      <= u100_next;
                u200_reg      <= u200_next;
            end
            if (res_push)
            begin
                sq_acc_reg <= sq_acc_next;
            end
            if (adv)
            begin
                s1_valid_reg <= word_pop;
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Advance stage payloads; stage two squares the run length
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_end_user_reg <= word.end_user;
            s1_rl_reg       <= rl;
            s1_res_reg      <= s1_res_next;
            s2_end_user_reg <= s1_end_user_reg;
            s2_sq_reg       <= SQ_W'(s1_rl_reg) * SQ_W'(s1_rl_reg);
            s2_res_reg      <= s1_res_reg;
        end
    end

endmodule

`default_nettype wire

@@ sv/xbar_chart_run_length_monitor.sv @@
// Channel   | Handshake        | Payload
// ----------+------------------+----------------------------------------------
// input     | push / full      | op, sample
// result    | empty / pop      | subgroup_done, alarm, run_length, totals
// config    | cfg_we           | cfg_index, cfg_data
//
// One word is taken per clock unless the middle queue is full; the front adds
// and compares combinationally and the back runs three stages (counters,
// run-length square, square sum). A result passes both stage registers and
// both queues to reach the result ports. The back stalls only when the result
// queue is full; the front then fills the middle queue and raises full. rst_n
// clears all state and both queues at once; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module xbar_chart_run_length_monitor #(
    parameter int MAX_SUBGROUP = 16,
    parameter int RUN_BITS     = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [xrlm_pkg::CFG_ADDR_W-1:0]      cfg_index,
    input  logic [xrlm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 op,
    input  logic signed [xrlm_pkg::SAMPLE_W-1:0] sample,
    output logic                                 empty,
    input  logic                                 pop,
    output logic                                 subgroup_done,
    output logic                                 alarm,
    output logic [xrlm_pkg::COUNT_W-1:0]         run_length,
    output logic [xrlm_pkg::COUNT_W-1:0]         alarm_total,
    output logic [xrlm_pkg::LSUM_W-1:0]          run_length_sum,
    output logic [xrlm_pkg::SQSUM_W-1:0]         run_length_square_sum,
    output logic [xrlm_pkg::COUNT_W-1:0]         runs_under_50,
    output logic [xrlm_pkg::COUNT_W-1:0]         runs_under_100,
    output logic [xrlm_pkg::COUNT_W-1:0]         runs_under_200
);

    import xrlm_pkg::*;

    localparam int MID_W = $bits(mid_word_t);
    localparam int RES_W = $bits(res_word_t);

    logic             accept;
    mid_word_t        front_word;
    logic [MID_W-1:0] mid_rd_data;
    mid_word_t        mid_head;
    logic             mid_empty;
    logic             mid_pop;
    res_word_t        back_res;
    logic             res_push;
    logic             res_full;
    logic [RES_W-1:0] res_rd_data;
    res_word_t        res_head;

    assign accept = push && !full;

    xrlm_front #(
        .MAX_SUBGROUP (MAX_SUBGROUP)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .op        (op),
        .sample    (sample),
        .word      (front_word)
    );

    // Middle queue between classification and statistics
    xrlm_fifo #(
        .WIDTH (MID_W),
        .DEPTH (4)
    ) u_mid_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (accept),
        .wr_data (front_word),
        .full    (full),
        .pop     (mid_pop),
        .rd_data (mid_rd_data),
        .empty   (mid_empty)
    );

    assign mid_head = mid_word_t'(mid_rd_data);

    xrlm_back #(
        .RUN_BITS (RUN_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (!mid_empty),
        .word       (mid_head),
        .word_pop   (mid_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (back_res)
    );

    // Result queue facing the consumer
    xrlm_fifo #(
        .WIDTH (RES_W),
        .DEPTH (4)
    ) u_res_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (back_res),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_rd_data),
        .empty   (empty)
    );

    assign res_head              = res_word_t'(res_rd_data);
    assign subgroup_done         = res_head.subgroup_done;
    assign alarm                 = res_head.alarm;
    assign run_length            = res_head.run_length;
    assign alarm_total           = res_head.alarm_total;
    assign run_length_sum        = res_head.run_length_sum;
    assign run_length_square_sum = res_head.run_length_square_sum;
    assign runs_under_50         = res_head.runs_under_50;
    assign runs_under_100        = res_head.runs_under_100;
    assign runs_under_200        = res_head.runs_under_200;

endmodule

`default_nettype wire

@@ sv/xrlm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "xbar_chart_run_length_monitor_assert.svh"

module xrlm_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         empty,
    input logic                         pop,
    input logic                         subgroup_done,
    input logic                         alarm,
    input logic [xrlm_pkg::COUNT_W-1:0] run_length,
    input logic [xrlm_pkg::COUNT_W-1:0] alarm_total,
    input logic [xrlm_pkg::LSUM_W-1:0]  run_length_sum,
    input logic [xrlm_pkg::COUNT_W-1:0] runs_under_50,
    input logic [xrlm_pkg::COUNT_W-1:0] runs_under_100,
    input logic [xrlm_pkg::COUNT_W-1:0] runs_under_200
);

    // An alarm only comes with a completed subgroup
    `XRLM_ASSERT_NOW(a_alarm_done, clk, rst_n, !empty && alarm, subgroup_done, "alarm without subgroup")

    // Run length is non-zero exactly on an alarm
    `XRLM_ASSERT_NOW(a_rl_alarm, clk, rst_n, !empty, alarm == (run_length != '0), "run length mismatch")

    // Short-run counters nest inside each other and the alarm total
    `XRLM_ASSERT_NOW(a_nesting, clk, rst_n, !empty, (runs_under_50 <= runs_under_100) && (runs_under_100 <= runs_under_200) && (runs_under_200 <= alarm_total), "short-run counters out of order")

    // Every alarm adds at least one to the run-length sum
    `XRLM_ASSERT_NOW(a_sum_total, clk, rst_n, !empty, run_length_sum >= 32'(alarm_total), "run-length sum below alarm total")

    // A waiting word holds until taken
    `XRLM_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(alarm_total) && $stable(run_length_sum), "result changed while waiting")

endmodule

bind xbar_chart_run_length_monitor xrlm_checker u_xrlm_checker (.*);

`default_nettype wire
